// ----- src/assert_macros.svh -----
// Assertion macros used by the pixel plot back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// a |-> b, checked at every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// a |=> b, checked at every clock edge outside reset
`define ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, a, b, msg)
`define ASSERT_NEXT(label, clk, rst, a, b, msg)
`endif
`endif

// ----- src/glcd_pkg.sv -----
// Package: geometry constants, bus command codes and word types of the pixel plotter.
package glcd_pkg;
   localparam int PAGE_COUNT   = 8;
   localparam int COLUMN_COUNT = 128;
   localparam int HALF_COLUMNS = 64;

   localparam int ROW_COUNT  = PAGE_COUNT * 8;
   localparam int DEPTH      = PAGE_COUNT * COLUMN_COUNT;
   localparam int PAGE_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int COL_W      = $clog2(COLUMN_COUNT);
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] PAGE_CMD   = 8'hB8;
   localparam logic [7:0] COLUMN_CMD = 8'h40;

   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_SET   = 1'b1;

   typedef struct packed {
      logic [7:0] pixel_row;
      logic [7:0] pixel_column;
      logic       opcode;
   } req_type;

   typedef struct packed {
      logic       is_data;
      logic       select_left;
      logic       select_right;
      logic [7:0] bus_byte;
      logic       last_write;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [PAGE_W-1:0] page;
      logic [COL_W-1:0]  column;
      logic [2:0]        bit_sel;
      logic              left;
      logic              set_pixel;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_status_type;
endpackage

// ----- src/glcd_front.sv -----
// Front end: accepts pixel requests, drops out-of-range ones, builds store jobs.
module glcd_front (
   input  logic             start,
   input  logic             busy,
   input  glcd_pkg::req_type req_word,
   output logic             push,
   output glcd_pkg::job_type job
);
   import glcd_pkg::*;

   logic in_range;
   logic [PAGE_W-1:0] page;
   logic [COL_W-1:0]  column;

   always_comb begin
      in_range = ({1'b0, req_word.pixel_row} < 9'(ROW_COUNT)) &&
                 ({1'b0, req_word.pixel_column} < 9'(COLUMN_COUNT));
      page     = PAGE_W'(req_word.pixel_row >> 3);
      column   = COL_W'(req_word.pixel_column);
      push     = start && !busy && in_range;
      job.page      = page;
      job.column    = column;
      job.addr      = ADDR_W'(32'(page) * 32'(COLUMN_COUNT) + 32'(column));
      job.bit_sel   = req_word.pixel_row[2:0];
      job.left      = {1'b0, req_word.pixel_column} < 9'(HALF_COLUMNS);
      job.set_pixel = (req_word.opcode == OP_SET);
   end
endmodule

// ----- src/glcd_queue.sv -----
// Two-entry job queue between the front end and the bus sequencer.
module glcd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  glcd_pkg::job_type         job_in,
   input  logic                      pop,
   output glcd_pkg::job_type         job_out,
   output glcd_pkg::queue_status_type status
);
   import glcd_pkg::*;

   job_type              entry_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      status.full  = (count_ff == Q_CNT_W'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      job_out      = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end
endmodule

// ----- src/glcd_back.sv -----
// Back end: frame store, clearing pass and the three-write bus sequencer.
`include "assert_macros.svh"
module glcd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  glcd_pkg::queue_status_type q_status,
   input  glcd_pkg::job_type          q_job,
   output glcd_pkg::back_status_type  status,
   output logic                       rsp_valid,
   output glcd_pkg::rsp_type          rsp_word
);
   import glcd_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_PAGE  = 3'd2;
   localparam logic [2:0] S_COL   = 3'd3;
   localparam logic [2:0] S_DATA  = 3'd4;

   logic [7:0]        frame_mem [DEPTH];
   logic [7:0]        rd_data_ff;
   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clear_ff, clear_in;
   job_type           job_ff, job_in;
   logic [7:0]        byte_ff, byte_in;
   logic              pop;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [7:0]        mem_wd;
   logic [7:0]        mask;
   logic [7:0]        new_byte;

   always_comb begin
      mask     = 8'd1 << job_ff.bit_sel;
      new_byte = job_ff.set_pixel ? (rd_data_ff | mask) : (rd_data_ff & ~mask);
      pop      = 1'b0;
      state_in = state_ff;
      clear_in = clear_ff;
      job_in   = job_ff;
      byte_in  = byte_ff;
      mem_we   = 1'b0;
      mem_wa   = job_ff.addr;
      mem_wd   = new_byte;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_wa   = clear_ff;
            mem_wd   = 8'h00;
            clear_in = clear_ff + 1'b1;
            if (clear_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               job_in   = q_job;
               state_in = S_PAGE;
            end
         end
         S_PAGE: begin
            mem_we   = 1'b1;
            byte_in  = new_byte;
            state_in = S_COL;
         end
         S_COL: begin
            state_in = S_DATA;
         end
         S_DATA: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               job_in   = q_job;
               state_in = S_PAGE;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid             = 1'b0;
      rsp_word.is_data      = 1'b0;
      rsp_word.select_left  = job_ff.left;
      rsp_word.select_right = !job_ff.left;
      rsp_word.last_write   = 1'b0;
      rsp_word.bus_byte     = PAGE_CMD + 8'(job_ff.page);
      unique case (state_ff)
         S_PAGE: begin
            rsp_valid             = 1'b1;
            rsp_word.select_left  = 1'b1;
            rsp_word.select_right = 1'b1;
         end
         S_COL: begin
            rsp_valid = 1'b1;
            if (job_ff.left) begin
               rsp_word.bus_byte = COLUMN_CMD + 8'(job_ff.column);
            end else begin
               rsp_word.bus_byte = COLUMN_CMD + 8'(job_ff.column) - 8'(HALF_COLUMNS);
            end
         end
         S_DATA: begin
            rsp_valid           = 1'b1;
            rsp_word.is_data    = 1'b1;
            rsp_word.last_write = 1'b1;
            rsp_word.bus_byte   = byte_ff;
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase
      status.clearing = (state_ff == S_CLEAR);
      status.pop      = pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clear_ff <= '0;
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      byte_ff <= byte_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= frame_mem[q_job.addr];
   end

   `ASSERT_IMPLY(a_no_rsp_in_clear, clock, reset, state_ff == S_CLEAR, !rsp_valid, "result during clear")
   `ASSERT_NEXT(a_page_then_col, clock, reset, state_ff == S_PAGE, state_ff == S_COL, "column write missing")
   `ASSERT_NEXT(a_col_then_data, clock, reset, state_ff == S_COL, state_ff == S_DATA, "data write missing")
   `ASSERT_IMPLY(a_pop_nonempty, clock, reset, pop, !q_status.empty, "pop from empty queue")
endmodule

// ----- src/glcd_pixel_plot_shadow_buffer_core.sv -----
// Top level: pixel plotter for a two-chip graphic LCD with a shadow frame store.
// After reset busy stays high while all 1024 bytes of the frame store are cleared, one
// byte a cycle. A request is taken when start is high and busy low; rows above 63 or
// columns above 127 are dropped with no writes. Each kept request produces three bus
// writes on consecutive cycles (page command, column command, data byte) once the bus
// sequencer has popped it from the queue; the sequencer works on one request at a time.
// A two-entry queue lets requests be taken while writes go out; busy is high when it is
// full. Each write is on rsp_word for one cycle with rsp_valid high and the receiver
// cannot stall it.
module glcd_pixel_plot_shadow_buffer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  glcd_pkg::req_type req_word,
   output logic              rsp_valid,
   output glcd_pkg::rsp_type rsp_word
);
   import glcd_pkg::*;

   logic             push;
   job_type          front_job;
   job_type          q_job;
   queue_status_type q_status;
   back_status_type  b_status;

   assign busy = b_status.clearing || q_status.full;

   glcd_front u_front (
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .push     (push),
      .job      (front_job)
   );

   glcd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .job_in  (front_job),
      .pop     (b_status.pop),
      .job_out (q_job),
      .status  (q_status)
   );

   glcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_job     (q_job),
      .status    (b_status),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );
endmodule
